// ===== rtl/etld_pkg.sv =====
// ----------------------------------------------------------------------------
// etld_pkg: shared types and constants for the epoch to local date converter
// Day and calendar constants, reciprocal multipliers for the constant
// divisions, and the pipeline stage record.
// ----------------------------------------------------------------------------
package etld_pkg;

    localparam int TS_W    = 32;
    localparam int ZONE_W  = 17;
    localparam int DATE_W  = 25;
    localparam int MS_W    = 27;
    localparam int TDATA_W = 56;
    localparam int NUM_STAGES = 14;

    localparam logic signed [ZONE_W-1:0] ZONE_RESET = -17'sd18000;

    // seconds per day is 128 * 675: shift by 7, then divide by 675
    localparam int DAY_LOW_BITS = 7;
    localparam int DAY_UNIT     = 675;
    localparam int DAY_SHIFT    = 35;
    localparam longint unsigned DAY_RECIP_L =
        ((64'd1 << DAY_SHIFT) + DAY_UNIT - 1) / DAY_UNIT;
    localparam logic [25:0] DAY_RECIP = 26'(DAY_RECIP_L);

    localparam logic [31:0] SEC_PER_DAY    = 32'd86400;
    localparam logic [19:0] DAYS_TO_EPOCH  = 20'd719468;
    localparam int          ERA_DAYS       = 146097;
    localparam int          CENT_DAYS      = 36524;
    localparam logic [17:0] ERA_LAST_DAY   = 18'd146096;
    localparam int          NUM_ERAS_MAX   = 5;
    localparam int          NUM_CENTS_MAX  = 4;

    localparam int QUAD_DAYS   = 1460;
    localparam int QUAD_SHIFT  = 28;
    localparam longint unsigned QUAD_RECIP_L =
        ((64'd1 << QUAD_SHIFT) + QUAD_DAYS - 1) / QUAD_DAYS;
    localparam logic [17:0] QUAD_RECIP = 18'(QUAD_RECIP_L);

    localparam int YEAR_DAYS  = 365;
    localparam int YEAR_SHIFT = 26;
    localparam longint unsigned YEAR_RECIP_L =
        ((64'd1 << YEAR_SHIFT) + YEAR_DAYS - 1) / YEAR_DAYS;
    localparam logic [17:0] YEAR_RECIP = 18'(YEAR_RECIP_L);

    localparam int YEARS_PER_CENT = 100;
    localparam int CENTS_PER_ERA  = 3;

    localparam int MONTH_SPAN  = 153;
    localparam int MONTH_PARTS = 5;
    localparam int MP_SHIFT    = 19;
    localparam longint unsigned MP_RECIP_L =
        ((64'd1 << MP_SHIFT) + MONTH_SPAN - 1) / MONTH_SPAN;
    localparam logic [11:0] MP_RECIP = 12'(MP_RECIP_L);

    localparam int MD_SHIFT = 14;
    localparam longint unsigned MD_RECIP_L =
        ((64'd1 << MD_SHIFT) + MONTH_PARTS - 1) / MONTH_PARTS;
    localparam logic [11:0] MD_RECIP = 12'(MD_RECIP_L);

    localparam logic [3:0]  MARCH_OFS      = 4'd3;
    localparam logic [3:0]  JAN_OFS        = 4'd9;
    localparam logic [3:0]  MP_JAN         = 4'd10;
    localparam logic [3:0]  FEB            = 4'd2;
    localparam logic [11:0] YEARS_PER_ERA  = 12'd400;
    localparam logic [26:0] MS_PER_SEC     = 27'd1000;
    localparam logic [24:0] YEAR_SCALE     = 25'd10000;
    localparam logic [24:0] MONTH_SCALE    = 25'd100;

    typedef struct packed {
        logic [31:0] local_s;
        logic [50:0] p_days;
        logic [15:0] days;
        logic [31:0] days_x;
        logic [19:0] z;
        logic [16:0] secs;
        logic [26:0] ms;
        logic [2:0]  era;
        logic [17:0] doe;
        logic [2:0]  q_cent;
        logic        q_era_last;
        logic [35:0] p_quad;
        logic [17:0] t;
        logic [35:0] p_year;
        logic [8:0]  yoe;
        logic [17:0] base;
        logic [8:0]  doy;
        logic [10:0] x;
        logic [22:0] p_mp;
        logic [3:0]  mp;
        logic [10:0] y;
        logic [22:0] p_md;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [24:0] date;
    } t_stage;

endpackage

// ===== rtl/epoch_to_local_date_and_time.sv =====
// ----------------------------------------------------------------------------
// epoch_to_local_date_and_time: UNIX time to local civil date and time of day
// Adds a signed zone offset, splits into days and seconds, and converts the
// day count to a Gregorian date packed as YYYYMMDD plus milliseconds of day.
// ----------------------------------------------------------------------------
//  channel   direction  payload (low bit first)
//  s_axis    in         tdata: timestamp_seconds[31:0]
//  m_axis    out        tdata: date_packed[24:0], ms_of_day[51:25], zero fill
//  cfg       in         wr_data: zone_offset_seconds[16:0] (signed)
//
//  fourteen register stages, one transaction per cycle while m_axis accepts
//  rate set by the stage chain; each stage holds one or more multiplies, adds or compares
//  synchronous active-low reset clears the valid bits and loads the offset
//  each stage advances when it is empty or the stage after it advances,
//  so a stall on m_axis fills bubbles before back-pressuring s_axis
// ----------------------------------------------------------------------------
module epoch_to_local_date_and_time (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [etld_pkg::ZONE_W-1:0] i_cfg_wr_data,  // zone_offset_seconds
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [etld_pkg::TS_W-1:0]   i_s_axis_tdata,  // timestamp_seconds
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [etld_pkg::TDATA_W-1:0] o_m_axis_tdata  // date_packed, ms_of_day
);
    import etld_pkg::*;

    logic [ZONE_W-1:0]     r_zone;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;
    t_stage                r_st [NUM_STAGES];
    t_stage                n_st [NUM_STAGES];
    logic [1:0]            c100;

    // stage enables
    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];
    assign o_m_axis_tdata  = {4'd0, r_st[NUM_STAGES-1].ms, r_st[NUM_STAGES-1].date};

    always_comb begin
        n_st[0] = r_st[0];
        n_st[0].local_s = i_s_axis_tdata + {{(TS_W-ZONE_W){r_zone[ZONE_W-1]}}, r_zone};

        n_st[1] = r_st[0];
        n_st[1].p_days = 51'(r_st[0].local_s[TS_W-1:DAY_LOW_BITS]) * 51'(DAY_RECIP);

        n_st[2] = r_st[1];
        n_st[2].days   = r_st[1].p_days[50:DAY_SHIFT];
        n_st[2].days_x = 32'(n_st[2].days) * SEC_PER_DAY;
        n_st[2].z      = 20'(n_st[2].days) + DAYS_TO_EPOCH;

        n_st[3] = r_st[2];
        n_st[3].secs = 17'(r_st[2].local_s - r_st[2].days_x);
        n_st[3].era  = 3'd0;
        for (int k = 1; k <= NUM_ERAS_MAX; k++) begin
            if (r_st[2].z >= 20'(k * ERA_DAYS)) begin
                n_st[3].era = 3'(k);
            end
        end
        n_st[3].doe = 18'(r_st[2].z - 20'(n_st[3].era) * 20'(ERA_DAYS));

        n_st[4] = r_st[3];
        n_st[4].ms     = 27'(r_st[3].secs) * MS_PER_SEC;
        n_st[4].p_quad = 36'(r_st[3].doe) * 36'(QUAD_RECIP);
        n_st[4].q_cent = 3'd0;
        for (int k = 1; k <= NUM_CENTS_MAX; k++) begin
            if (r_st[3].doe >= 18'(k * CENT_DAYS)) begin
                n_st[4].q_cent = 3'(k);
            end
        end
        n_st[4].q_era_last = (r_st[3].doe >= ERA_LAST_DAY);

        n_st[5] = r_st[4];
        n_st[5].t = r_st[4].doe - 18'(r_st[4].p_quad >> QUAD_SHIFT)
                  + 18'(r_st[4].q_cent) - 18'(r_st[4].q_era_last);

        n_st[6] = r_st[5];
        n_st[6].p_year = 36'(r_st[5].t) * 36'(YEAR_RECIP);

        n_st[7] = r_st[6];
        n_st[7].yoe = 9'(r_st[6].p_year >> YEAR_SHIFT);
        c100 = 2'd0;
        for (int k = 1; k <= CENTS_PER_ERA; k++) begin
            if (n_st[7].yoe >= 9'(k * YEARS_PER_CENT)) begin
                c100 = 2'(k);
            end
        end
        n_st[7].base = 18'(n_st[7].yoe) * 18'(YEAR_DAYS) + 18'(n_st[7].yoe[8:2])
                     - 18'(c100);

        n_st[8] = r_st[7];
        n_st[8].doy = 9'(r_st[7].doe - r_st[7].base);
        n_st[8].x   = 11'(n_st[8].doy) * 11'(MONTH_PARTS) + 11'd2;

        n_st[9] = r_st[8];
        n_st[9].p_mp = 23'(r_st[8].x) * 23'(MP_RECIP);

        n_st[10] = r_st[9];
        n_st[10].mp = 4'(r_st[9].p_mp >> MP_SHIFT);
        n_st[10].y  = 11'(n_st[10].mp) * 11'(MONTH_SPAN) + 11'd2;

        n_st[11] = r_st[10];
        n_st[11].p_md = 23'(r_st[10].y) * 23'(MD_RECIP);

        n_st[12] = r_st[11];
        n_st[12].day   = 5'(r_st[11].doy - 9'(r_st[11].p_md >> MD_SHIFT) + 9'd1);
        n_st[12].month = (r_st[11].mp < MP_JAN) ? r_st[11].mp + MARCH_OFS
                                                : r_st[11].mp - JAN_OFS;
        n_st[12].year  = 12'(r_st[11].yoe) + 12'(r_st[11].era) * YEARS_PER_ERA
                       + 12'(n_st[12].month <= FEB);

        n_st[13] = r_st[12];
        n_st[13].date = 25'(r_st[12].year) * YEAR_SCALE
                      + 25'(r_st[12].month) * MONTH_SCALE + 25'(r_st[12].day);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: epoch to local date and time converter
// Drives UNIX timestamps over the input stream under several zone offsets,
// predicts the local YYYYMMDD date and milliseconds of day for each accepted
// transaction, and compares every output transaction in order. Both stream
// sides idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import etld_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT = 21;

    typedef struct packed {
        logic [MS_W-1:0]   ms;
        logic [DATE_W-1:0] date;
    } t_civil;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [ZONE_W-1:0]      i_cfg_wr_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [TS_W-1:0]        i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     o_m_axis_tdata;

    logic [ZONE_W-1:0]      zone_model = ZONE_RESET;
    t_civil                 pending_dates[$];
    int                     err_cnt = 0;
    int                     quiet_cycles = 0;
    bit                     steady = 1'b0;
    bit                     hold_req = 1'b0;

    epoch_to_local_date_and_time dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_civil civil_from_epoch(input logic [TS_W-1:0] ts,
                                                input logic [ZONE_W-1:0] zone);
        int unsigned local_sec, day_count, sec_of_day, shifted, era_idx;
        int unsigned day_of_era, year_of_era, day_of_year, month_idx;
        int unsigned dom, mon, yr;
        t_civil res;
        local_sec = ts + {{(32-ZONE_W){zone[ZONE_W-1]}}, zone};
        day_count = local_sec / 86400;
        sec_of_day = local_sec % 86400;
        shifted = day_count + 719468;
        era_idx = shifted / 146097;
        day_of_era = shifted - era_idx * 146097;
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4
                                    - year_of_era / 100);
        month_idx = (5 * day_of_year + 2) / 153;
        dom = day_of_year - (153 * month_idx + 2) / 5 + 1;
        mon = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
        yr = year_of_era + era_idx * 400 + ((mon <= 2) ? 1 : 0);
        res.date = DATE_W'(yr * 10000 + mon * 100 + dom);
        res.ms = MS_W'(sec_of_day * 1000);
        return res;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_civil want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_dates.size() == 0) begin
                $error("unexpected output transaction, tdata %h", o_m_axis_tdata);
                err_cnt++;
            end else begin
                want = pending_dates.pop_front();
                if (o_m_axis_tdata[DATE_W-1:0] !== want.date) begin
                    $error("date_packed: expected %0d, actual %0d",
                           want.date, o_m_axis_tdata[DATE_W-1:0]);
                    err_cnt++;
                end
                if (o_m_axis_tdata[DATE_W+MS_W-1:DATE_W] !== want.ms) begin
                    $error("ms_of_day: expected %0d, actual %0d",
                           want.ms, o_m_axis_tdata[DATE_W+MS_W-1:DATE_W]);
                    err_cnt++;
                end
                if (o_m_axis_tdata[TDATA_W-1:DATE_W+MS_W] !== '0) begin
                    $error("zero fill: expected 0, actual %h",
                           o_m_axis_tdata[TDATA_W-1:DATE_W+MS_W]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog on transaction progress
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // output side ready with random idling and one long hold
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_timestamp(input logic [TS_W-1:0] ts);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= $urandom();
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= ts;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_dates.push_back(civil_from_epoch(ts, zone_model));
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_zone(input logic [ZONE_W-1:0] value);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= ZONE_W'($urandom());
        zone_model = value;
    endtask

    function automatic logic [TS_W-1:0] random_timestamp();
        logic [TS_W-1:0] ts;
        logic [TS_W-1:0] zone_ext;
        zone_ext = {{(32-ZONE_W){zone_model[ZONE_W-1]}}, zone_model};
        case ($urandom_range(9))
            0, 1, 2, 3, 4: ts = $urandom();
            5, 6, 7: ts = $urandom_range(0, 49710) * 86400 - zone_ext
                          + $urandom_range(0, 4) - 2;
            8: ts = $urandom_range(0, 1) ? $urandom_range(0, 200000)
                                         : 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: ts = {1'b1, 31'($urandom())};
        endcase
        return ts;
    endfunction

    // calendar corners under the reset offset
    task automatic test_calendar_corners;
        logic [TS_W-1:0] corner_ts[] = '{
            32'd0, 32'hFFFF_FFFF, 32'd18000, 32'd17999, 32'd104399,
            32'd68169600, 32'd951800400, 32'd951886799, 32'd946702799,
            32'd4107474000, 32'd4107560400, 32'h5555_5555, 32'hAAAA_AAAA
        };
        foreach (corner_ts[k]) send_timestamp(corner_ts[k]);
    endtask

    // offset extremes, in and out of the nominal range
    task automatic test_zone_extremes;
        logic [ZONE_W-1:0] zones[] = '{
            17'sd50400, -17'sd50400, 17'd0, 17'h0FFFF, 17'h10000, 17'h1FFFF
        };
        foreach (zones[k]) begin
            set_zone(zones[k]);
            send_timestamp(32'd0);
            send_timestamp(32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random_stream;
        logic [ZONE_W-1:0] zone;
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 3)
                zone = ZONE_W'($urandom());
            else
                zone = ZONE_W'($urandom_range(0, 100800) - 50400);
            set_zone(zone);
            steady = (phase == 2);
            repeat (100) send_timestamp(random_timestamp());
            steady = 1'b0;
        end
    endtask

    // long output hold while the input keeps offering
    task automatic test_output_hold;
        set_zone(ZONE_RESET);
        hold_req = 1'b1;
        steady = 1'b1;
        repeat (40) send_timestamp(random_timestamp());
        steady = 1'b0;
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_calendar_corners();
        test_zone_extremes();
        test_random_stream();
        test_output_hold();
        drain();
        repeat (2 * NUM_STAGES) @(posedge i_clk);
        if (err_cnt == 0 && pending_dates.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== epoch_to_local_date_and_time.f =====
rtl/etld_pkg.sv
rtl/epoch_to_local_date_and_time.sv
dv/testbench.sv
